>>> sv/pfl_pkg.sv
// Shared types and constants for the palette store with fade lookup.
package pfl_pkg;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd17;
  localparam logic [7:0] BYTE_MAX = 8'hff;
  localparam int APB_AW = 3;

  localparam logic REG_DARK_SELECT = 1'b0;
  localparam logic REG_WHITE_BORDER = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FIND   = 2'd2,
    OP_FADE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] color_index;
    logic       bank;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [5:0] fade_amount;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] index_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rsp_t;

endpackage

>>> sv/palette_store_fade_lookup.sv
// Top level of the two-bank palette store with append, find and fade read.
//
// The palette lives in two RAMs, one per bank, each ENTRIES deep with a
// registered read. After reset a clearing pass zeroes both banks, one
// index a cycle, while no command is taken (configuration writes still
// land). One command is handled at a time: write and append finish in the
// execute state, fade read passes through entry read, reciprocal
// multiply, fade multiply and clamp, and find walks the used range of
// the selected bank through its read port, one entry a cycle, until a
// match or the end of the range. A finished result sits in an output
// register so the next command can be accepted while it waits to be taken.
module palette_store_fade_lookup #(
  parameter int ENTRIES = 256,
  parameter int FADE_SHADES = 20,
  parameter int FADE_WHITEOUT = 40,
  parameter int FIXED_COLORS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  pfl_pkg::cmd_t             cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output pfl_pkg::rsp_t             rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pfl_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam int CNT_W = pfl_pkg::COUNT_W;
  localparam int RECIP_SH = 16;
  localparam int RECIP = (2 ** RECIP_SH + FADE_SHADES - 1) / FADE_SHADES;
  localparam int SPAN = FADE_WHITEOUT - FADE_SHADES;
  localparam int WSTEP = 255 / ((SPAN > 0) ? SPAN : 1);
  localparam logic signed [8:0] SPAN_S = 9'(SPAN);
  localparam logic signed [17:0] WSTEP_S = 18'(WSTEP);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_FIND  = 7'b0001000,
    S_FQ    = 7'b0010000,
    S_FMUL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  pfl_pkg::cmd_t it;
  pfl_pkg::rsp_t res;
  logic [CNT_W-1:0] count;
  logic [AW-1:0] clr;
  logic [CW-1:0] scan;
  logic [CW-1:0] chk_idx;
  logic chk;
  logic dark_select;
  logic fade_to_white_border;
  logic [7:0] q_r, q_g, q_b;
  logic [23:0] ent;

  logic we0, we1;
  logic [AW-1:0] waddr, raddr;
  logic [23:0] wdata;
  logic [23:0] rdata0, rdata1, rsel;
  logic [23:0] it_rgb;
  logic full, idx_in_range, scan_end, match;
  logic [24:0] prod_r, prod_g, prod_b;
  logic [13:0] dk_r, dk_g, dk_b;
  logic signed [8:0] wdiff;
  logic signed [17:0] wprod;
  logic [7:0] wlevel;
  logic fixed_color, amt_is_shades, amt_above;

  assign pready = 1'b1;
  assign cmd_stall = (state != S_IDLE);

  assign it_rgb = {it.red_in, it.green_in, it.blue_in};
  assign rsel = dark_select ? rdata1 : rdata0;
  assign full = (count >= CNT_W'(ENTRIES));
  assign idx_in_range = ({1'b0, it.color_index} < 9'(ENTRIES));
  assign scan_end = (CNT_W'(scan) >= count) || (scan >= CW'(ENTRIES));
  assign match = (rsel == it_rgb);

  assign prod_r = 25'(rsel[23:16]) * 25'(RECIP);
  assign prod_g = 25'(rsel[15:8]) * 25'(RECIP);
  assign prod_b = 25'(rsel[7:0]) * 25'(RECIP);

  assign dk_r = 14'(q_r) * 14'(it.fade_amount);
  assign dk_g = 14'(q_g) * 14'(it.fade_amount);
  assign dk_b = 14'(q_b) * 14'(it.fade_amount);

  assign wdiff = $signed({3'b000, it.fade_amount}) - SPAN_S;
  assign wprod = WSTEP_S * 18'(wdiff);

  always_comb begin
    if (SPAN <= 0) begin
      wlevel = pfl_pkg::BYTE_MAX;
    end else if (wprod < 0) begin
      wlevel = 8'd0;
    end else if (wprod > 18'sd255) begin
      wlevel = pfl_pkg::BYTE_MAX;
    end else begin
      wlevel = wprod[7:0];
    end
  end

  assign fixed_color = ({1'b0, it.color_index} < 9'(FIXED_COLORS));
  assign amt_is_shades = ({1'b0, it.fade_amount} == 7'(FADE_SHADES));
  assign amt_above = ({1'b0, it.fade_amount} > 7'(FADE_SHADES));

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    waddr = it.color_index[AW-1:0];
    wdata = it_rgb;
    raddr = (state == S_FIND) ? scan[AW-1:0] : it.color_index[AW-1:0];
    case (state)
      S_CLEAR: begin
        we0 = 1'b1;
        we1 = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      S_EXEC: begin
        case (it.opcode)
          pfl_pkg::OP_WRITE: begin
            we0 = idx_in_range && !it.bank;
            we1 = idx_in_range && it.bank;
          end
          pfl_pkg::OP_APPEND: begin
            we0 = !full;
            we1 = !full;
            waddr = count[AW-1:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  pfl_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_bank_normal (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  pfl_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_bank_dark (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_select <= 1'b0;
      fade_to_white_border <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        pfl_pkg::REG_DARK_SELECT: dark_select <= pwdata[0];
        pfl_pkg::REG_WHITE_BORDER: fade_to_white_border <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pfl_pkg::REG_DARK_SELECT: prdata = {31'b0, dark_select};
      pfl_pkg::REG_WHITE_BORDER: prdata = {31'b0, fade_to_white_border};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      count <= pfl_pkg::COUNT_RESET;
      rsp_valid <= 1'b0;
      chk <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            it <= cmd;
            res <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          scan <= '0;
          chk <= 1'b0;
          case (it.opcode)
            pfl_pkg::OP_WRITE: begin
              state <= S_DONE;
            end
            pfl_pkg::OP_APPEND: begin
              if (full) begin
                res.status <= pfl_pkg::ST_FULL;
              end else begin
                res.index_out <= count[7:0];
                count <= count + 1'b1;
              end
              state <= S_DONE;
            end
            pfl_pkg::OP_FIND: begin
              state <= S_FIND;
            end
            pfl_pkg::OP_FADE: begin
              if (idx_in_range) begin
                state <= S_FQ;
              end else begin
                res.status <= pfl_pkg::ST_NOT_FOUND;
                state <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_FIND: begin
          if (chk && match) begin
            res.index_out <= 8'(chk_idx);
            chk <= 1'b0;
            state <= S_DONE;
          end else if (scan_end) begin
            res.status <= pfl_pkg::ST_NOT_FOUND;
            chk <= 1'b0;
            state <= S_DONE;
          end else begin
            chk <= 1'b1;
            chk_idx <= scan;
            scan <= scan + 1'b1;
          end
        end
        S_FQ: begin
          ent <= rsel;
          q_r <= prod_r[RECIP_SH+7:RECIP_SH];
          q_g <= prod_g[RECIP_SH+7:RECIP_SH];
          q_b <= prod_b[RECIP_SH+7:RECIP_SH];
          state <= S_FMUL;
        end
        S_FMUL: begin
          if (fixed_color && !amt_is_shades) begin
            if (it.color_index == 8'd0 && amt_above && fade_to_white_border) begin
              res.red_out <= wlevel;
              res.green_out <= wlevel;
              res.blue_out <= wlevel;
            end else begin
              res.red_out <= (|dk_r[13:8]) ? pfl_pkg::BYTE_MAX : dk_r[7:0];
              res.green_out <= (|dk_g[13:8]) ? pfl_pkg::BYTE_MAX : dk_g[7:0];
              res.blue_out <= (|dk_b[13:8]) ? pfl_pkg::BYTE_MAX : dk_b[7:0];
            end
          end else begin
            res.red_out <= ent[23:16];
            res.green_out <= ent[15:8];
            res.blue_out <= ent[7:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp <= res;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("color count beyond store depth");

  a_find_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && chk) |-> (CNT_W'(chk_idx) < count))
    else $error("find compares an entry outside the used range");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && state == S_IDLE))
    else $error("finished result not moved to output");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state == S_EXEC && cmd_stall))
    else $error("accepted beat not dispatched");
`endif

endmodule

>>> sv/pfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
